// ----- sv/tssr_pkg.sv -----
`default_nettype none

package tssr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SPD_W     = 25;
    localparam int CFG_W     = 24;
    localparam int STEP_W    = 28;
    localparam int NUM_W     = 2 * CFG_W;
    localparam int DEN_W     = 22;
    localparam int DIV_BITS  = 2;
    localparam int DIV_ITERS = STEP_W / DIV_BITS;
    localparam int CNT_W     = $clog2(DIV_ITERS);
    localparam int CFG_IDX_W = 2;

    localparam int ONE_Q = 1 << FRAC_BITS;

    localparam logic [SPD_W-1:0] ONE_V     = SPD_W'(ONE_Q);
    localparam logic [SPD_W-1:0] TH_STOP   = SPD_W'((ONE_Q + 50) / 100);
    localparam logic [SPD_W-1:0] TH_PLAY   = SPD_W'((11 * ONE_Q + 5) / 10);
    localparam logic [SPD_W-1:0] TH_NEAR0  = SPD_W'((ONE_Q + 10) / 20);
    localparam logic [SPD_W-1:0] TH_REV    = SPD_W'((ONE_Q + 500) / 1000);
    localparam logic [SPD_W-1:0] TH_SHUT   = SPD_W'((3 * ONE_Q + 1) / 2);
    localparam logic [SPD_W-1:0] TH_SILENT = SPD_W'((2 * ONE_Q + 500) / 1000);
    localparam logic [SPD_W-1:0] INR_LO    = SPD_W'(15 * ONE_Q);
    localparam logic [SPD_W-1:0] INR_HI    = SPD_W'(60 * ONE_Q);
    localparam logic [SPD_W-1:0] MAX_REEL  = SPD_W'((1 << (SPD_W - 1)) - 1);
    localparam logic [DEN_W-1:0] DEN_ALT   = DEN_W'(39);

    localparam logic [CFG_W-1:0] BRAKE_RST   = CFG_W'(93207);
    localparam logic [CFG_W-1:0] PLAY_RST    = CFG_W'(582);
    localparam logic [CFG_W-1:0] SHUTTLE_RST = CFG_W'(55924);

    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTTLE = 2'd2;

    typedef struct packed {
        logic take;
        logic sel;
        logic ld_alt;
        logic div_step;
        logic alt;
        logic ld_inr;
        logic quo;
        logic ramp;
    } t_cmd;

    typedef struct packed {
        logic need_alt;
        logic need_inr;
        logic div_last;
    } t_stat;

endpackage

`default_nettype wire

// ----- sv/transport_speed_slew_ramp_core.sv -----
// Each input beat is taken in IDLE, then the step is selected (SEL); when shuttling down
// into play a multiply and a radix-4 divide by 39 follow, and when |speed| > 15 an
// inertia divide follows. One item in flight: a new beat is taken only after the result
// is registered, and both divides use the shared two-bit-per-cycle divider.
// Reset (synchronous, active low): speed zero, direction forward, configuration
// step registers at their defaults, no result pending.
`default_nettype none

module transport_speed_slew_ramp_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [tssr_pkg::SPD_W-1:0]    i_target_speed,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [tssr_pkg::SPD_W-1:0]         o_new_speed,
    output logic signed [tssr_pkg::SPD_W-1:0]         o_reel_speed,
    output logic                                      o_reversed,
    output logic                                      o_silent,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [tssr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [tssr_pkg::CFG_W-1:0]           i_cfg_data
);
    import tssr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    tssr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tssr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_target_speed (i_target_speed),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_new_speed    (o_new_speed),
        .o_reel_speed   (o_reel_speed),
        .o_reversed     (o_reversed),
        .o_silent       (o_silent)
    );

endmodule

`default_nettype wire

// ----- sv/tssr_div.sv -----
`default_nettype none

module tssr_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic                          i_step,
    input  wire logic [tssr_pkg::NUM_W-1:0]    i_num,
    input  wire logic [tssr_pkg::DEN_W-1:0]    i_den,
    output logic      [tssr_pkg::STEP_W-1:0]   o_quo,
    output logic                               o_last
);
    import tssr_pkg::*;

    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0] r_nlo, n_nlo;
    logic [DEN_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W:0]    w_trial;
    logic              w_take;

    always_comb begin
        n_rem   = r_rem;
        n_nlo   = r_nlo;
        w_trial = '0;
        w_take  = 1'b0;
        for (int k = 0; k < DIV_BITS; k++) begin
            w_trial = {n_rem, n_nlo[STEP_W-1]};
            w_take  = (w_trial >= {1'b0, r_den});
            n_rem   = w_take ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
            n_nlo   = {n_nlo[STEP_W-2:0], w_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= {{(DEN_W - (NUM_W - STEP_W)){1'b0}}, i_num[NUM_W-1:STEP_W]};
            r_nlo <= i_num[STEP_W-1:0];
            r_den <= i_den;
        end else if (i_step) begin
            r_rem <= n_rem;
            r_nlo <= n_nlo;
        end
    end

    assign o_quo  = r_nlo;
    assign o_last = (r_cnt == CNT_W'(DIV_ITERS - 1));

endmodule

`default_nettype wire

// ----- sv/tssr_dp.sv -----
`default_nettype none

module tssr_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire tssr_pkg::t_cmd                       i_cmd,
    output tssr_pkg::t_stat                           o_stat,
    input  wire logic signed [tssr_pkg::SPD_W-1:0]    i_target_speed,
    input  wire logic                                 i_cfg_we,
    input  wire logic [tssr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [tssr_pkg::CFG_W-1:0]           i_cfg_data,
    output logic signed [tssr_pkg::SPD_W-1:0]         o_new_speed,
    output logic signed [tssr_pkg::SPD_W-1:0]         o_reel_speed,
    output logic                                      o_reversed,
    output logic                                      o_silent
);
    import tssr_pkg::*;

    localparam int XW   = STEP_W + 1;
    localparam int N15W = STEP_W + 4;

    logic [CFG_W-1:0]  r_brake, r_play, r_shuttle;
    logic [SPD_W-1:0]  r_tgt, r_cur, n_cur;
    logic              r_rev, n_rev;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_prod;
    logic [SPD_W-1:0]  r_o_tape, r_o_reel;
    logic              r_o_rev, r_o_silent;

    logic [SPD_W-1:0]  w_tm, w_cm, w_cm_m1, w_nm, w_reel;
    logic              w_stop, w_play_t, w_play_c, w_near0, w_same, w_faster;
    logic [CFG_W-1:0]  w_base;
    logic [NUM_W-1:0]  w_prod, w_num;
    logic [N15W-1:0]   w_n15;
    logic [DEN_W-1:0]  w_den;
    logic [STEP_W-1:0] w_quo, w_play_x, w_alt;
    logic              w_div_last;
    logic [XW-1:0]     w_tgt_x, w_cur_x, w_step_x, w_diff, w_dmag, w_new_x;
    logic              w_want;

    assign w_tm = r_tgt[SPD_W-1] ? (~r_tgt + SPD_W'(1)) : r_tgt;
    assign w_cm = r_cur[SPD_W-1] ? (~r_cur + SPD_W'(1)) : r_cur;

    assign w_stop   = (w_tm < TH_STOP);
    assign w_play_t = (w_tm <= TH_PLAY);
    assign w_play_c = (w_cm <= TH_PLAY);
    assign w_near0  = (w_cm < TH_NEAR0);
    assign w_same   = (r_tgt[SPD_W-1] == r_cur[SPD_W-1]);
    assign w_faster = (w_tm > w_cm);

    always_comb begin
        if (w_stop) begin
            w_base = r_brake;
        end else if (w_play_t) begin
            w_base = r_play;
        end else if (w_near0 || (w_same && w_faster)) begin
            w_base = r_shuttle;
        end else begin
            w_base = r_brake;
        end
    end

    assign w_cm_m1 = w_cm - ONE_V;
    assign w_prod  = r_brake * w_cm_m1[CFG_W-1:0];

    assign w_n15 = {r_step, 4'b0000} - {4'b0000, r_step};
    assign w_num = i_cmd.ld_alt ? NUM_W'(r_prod >> FRAC_BITS)
                                : (NUM_W'(w_n15) << FRAC_BITS);
    assign w_den = i_cmd.ld_alt ? DEN_ALT
                 : ((w_cm < INR_HI) ? w_cm[DEN_W-1:0] : INR_HI[DEN_W-1:0]);

    tssr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_cmd.ld_alt | i_cmd.ld_inr),
        .i_step  (i_cmd.div_step),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quo   (w_quo),
        .o_last  (w_div_last)
    );

    assign w_play_x = {{(STEP_W - CFG_W){1'b0}}, r_play};
    assign w_alt    = (w_quo > w_play_x) ? w_quo : w_play_x;

    assign w_tgt_x  = {{(XW - SPD_W){r_tgt[SPD_W-1]}}, r_tgt};
    assign w_cur_x  = {{(XW - SPD_W){r_cur[SPD_W-1]}}, r_cur};
    assign w_step_x = {1'b0, r_step};
    assign w_diff   = w_tgt_x - w_cur_x;
    assign w_dmag   = w_diff[XW-1] ? (~w_diff + XW'(1)) : w_diff;

    always_comb begin
        if (w_dmag <= w_step_x) begin
            w_new_x = w_tgt_x;
        end else if (w_diff[XW-1]) begin
            w_new_x = w_cur_x - w_step_x;
        end else begin
            w_new_x = w_cur_x + w_step_x;
        end
    end

    assign n_cur  = w_new_x[SPD_W-1:0];
    assign w_nm   = n_cur[SPD_W-1] ? (~n_cur + SPD_W'(1)) : n_cur;
    assign w_reel = r_rev ? (~w_nm + SPD_W'(1))
                          : ((w_nm > MAX_REEL) ? MAX_REEL : w_nm);
    assign w_want = n_cur[SPD_W-1] && (w_nm > TH_REV);
    assign n_rev  = ((w_want != r_rev) && ((w_tm > TH_SHUT) || (w_nm < TH_NEAR0)))
                  ? w_want : r_rev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brake   <= BRAKE_RST;
            r_play    <= PLAY_RST;
            r_shuttle <= SHUTTLE_RST;
            r_cur     <= '0;
            r_rev     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BRAKE:   r_brake   <= i_cfg_data;
                    CFG_PLAY:    r_play    <= i_cfg_data;
                    CFG_SHUTTLE: r_shuttle <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.ramp) begin
                r_cur <= n_cur;
                r_rev <= n_rev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_tgt <= i_target_speed;
        end
        if (i_cmd.sel) begin
            r_step <= {{(STEP_W - CFG_W){1'b0}}, w_base};
            r_prod <= w_prod;
        end else if (i_cmd.alt) begin
            r_step <= w_alt;
        end else if (i_cmd.quo) begin
            r_step <= w_quo;
        end
        if (i_cmd.ramp) begin
            r_o_tape   <= n_cur;
            r_o_reel   <= w_reel;
            r_o_rev    <= n_rev;
            r_o_silent <= (w_nm < TH_SILENT);
        end
    end

    assign o_stat.need_alt = !w_stop && w_play_t && !w_play_c;
    assign o_stat.need_inr = (w_cm > INR_LO);
    assign o_stat.div_last = w_div_last;

    assign o_new_speed  = r_o_tape;
    assign o_reel_speed = r_o_reel;
    assign o_reversed   = r_o_rev;
    assign o_silent     = r_o_silent;

endmodule

`default_nettype wire

// ----- sv/tssr_ctrl.sv -----
`default_nettype none

module tssr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire tssr_pkg::t_stat  i_stat,
    output tssr_pkg::t_cmd        o_cmd
);
    import tssr_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SEL  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_DIV1 = 4'd3;
    localparam logic [3:0] S_ALT  = 4'd4;
    localparam logic [3:0] S_INR  = 4'd5;
    localparam logic [3:0] S_DIV2 = 4'd6;
    localparam logic [3:0] S_QUO  = 4'd7;
    localparam logic [3:0] S_RAMP = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_cmd       w_cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        w_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.take = 1'b1;
                    n_state    = S_SEL;
                end
            end
            S_SEL: begin
                w_cmd.sel = 1'b1;
                n_state   = i_stat.need_alt ? S_MUL : S_INR;
            end
            S_MUL: begin
                w_cmd.ld_alt = 1'b1;
                n_state      = S_DIV1;
            end
            S_DIV1: begin
                w_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_ALT;
                end
            end
            S_ALT: begin
                w_cmd.alt = 1'b1;
                n_state   = S_INR;
            end
            S_INR: begin
                if (i_stat.need_inr) begin
                    w_cmd.ld_inr = 1'b1;
                    n_state      = S_DIV2;
                end else begin
                    n_state = S_RAMP;
                end
            end
            S_DIV2: begin
                w_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_QUO;
                end
            end
            S_QUO: begin
                w_cmd.quo = 1'b1;
                n_state   = S_RAMP;
            end
            S_RAMP: begin
                // hold until the output register frees up
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.ramp  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    a_ramp_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ramp |-> (!r_out_valid || i_out_ready))
        else $error("result written over a beat not yet taken");

    a_ramp_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ramp |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented after ramp");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV1 && i_stat.div_last) |=> (r_state == S_ALT))
        else $error("divider exit missed");

    a_take_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SEL && !o_in_ready))
        else $error("accepted beat not processed");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
module tb;

    localparam int SW = tssr_pkg::SPD_W;
    localparam int CW = tssr_pkg::CFG_W;

    localparam longint ONE_Q      = longint'(1) << tssr_pkg::FRAC_BITS;
    localparam longint LIM_STOP   = (ONE_Q + 50) / 100;
    localparam longint LIM_PLAY   = (11 * ONE_Q + 5) / 10;
    localparam longint LIM_NEAR0  = (ONE_Q + 10) / 20;
    localparam longint LIM_REV    = (ONE_Q + 500) / 1000;
    localparam longint LIM_SHUT   = (3 * ONE_Q + 1) / 2;
    localparam longint LIM_SILENT = (2 * ONE_Q + 500) / 1000;
    localparam longint REEL_MAX   = (longint'(1) << (SW - 1)) - 1;
    localparam longint SPD_SPAN   = 160 * ONE_Q;

    localparam logic signed [SW-1:0] SPD_MIN = {1'b1, {(SW - 1){1'b0}}};
    localparam logic signed [SW-1:0] SPD_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [CW-1:0] STEP_MAX = {CW{1'b1}};
    localparam logic [tssr_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic signed [SW-1:0] tape;
        logic signed [SW-1:0] reel;
        logic                 rev;
        logic                 silent;
    } t_speed_rec;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    logic signed [SW-1:0]              i_target_speed = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic signed [SW-1:0]              o_new_speed;
    logic signed [SW-1:0]              o_reel_speed;
    logic                              o_reversed;
    logic                              o_silent;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [tssr_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CW-1:0]                     i_cfg_data = '0;

    logic signed [SW-1:0] spd_q = '0;
    logic                 rev_q = 1'b0;
    logic [CW-1:0]        brake_q = tssr_pkg::BRAKE_RST;
    logic [CW-1:0]        play_q = tssr_pkg::PLAY_RST;
    logic [CW-1:0]        shuttle_q = tssr_pkg::SHUTTLE_RST;

    t_speed_rec pending_speeds[$];
    int mismatches = 0;
    int stall_cycles = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;

    transport_speed_slew_ramp_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_target_speed (i_target_speed),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_new_speed    (o_new_speed),
        .o_reel_speed   (o_reel_speed),
        .o_reversed     (o_reversed),
        .o_silent       (o_silent),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_speed_rec slew_next(input logic signed [SW-1:0] tgt_in,
                                             input logic signed [SW-1:0] spd_in,
                                             input logic rev_in);
        longint tgt, spd, tm, cm, step, alt, den, diff, nm, reel;
        logic want, rev;
        t_speed_rec r;
        tgt = tgt_in;
        spd = spd_in;
        tm = mag(tgt);
        cm = mag(spd);
        rev = rev_in;
        if (tm < LIM_STOP) begin
            step = longint'(brake_q);
        end else if (tm <= LIM_PLAY) begin
            if (cm <= LIM_PLAY) begin
                step = longint'(play_q);
            end else begin
                alt = (longint'(brake_q) * (cm - ONE_Q)) / (39 * ONE_Q);
                step = (alt > longint'(play_q)) ? alt : longint'(play_q);
            end
        end else if (cm < LIM_NEAR0 || (((tgt < 0) == (spd < 0)) && tm > cm)) begin
            step = longint'(shuttle_q);
        end else begin
            step = longint'(brake_q);
        end
        if (cm > 15 * ONE_Q) begin
            den = (cm < 60 * ONE_Q) ? cm : 60 * ONE_Q;
            step = (step * 15 * ONE_Q) / den;
        end
        diff = tgt - spd;
        if (mag(diff) <= step) spd = tgt;
        else if (diff > 0) spd = spd + step;
        else spd = spd - step;
        nm = mag(spd);
        reel = rev_in ? -nm : nm;
        if (reel > REEL_MAX) reel = REEL_MAX;
        want = (spd < -LIM_REV);
        if (want != rev && (tm > LIM_SHUT || nm < LIM_NEAR0)) rev = want;
        r.tape = spd[SW-1:0];
        r.reel = reel[SW-1:0];
        r.rev = rev;
        r.silent = (nm < LIM_SILENT);
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [SW-1:0] want,
                               input logic signed [SW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_speed_rec want_rec;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_speeds.size() == 0) begin
                    $display("%0t: unexpected beat, new_speed expected none actual %0d",
                             $time, o_new_speed);
                    mismatches++;
                end else begin
                    want_rec = pending_speeds.pop_front();
                    check_field("new_speed", want_rec.tape, o_new_speed);
                    check_field("reel_speed", want_rec.reel, o_reel_speed);
                    check_field("reversed", want_rec.rev, o_reversed);
                    check_field("silent", want_rec.silent, o_silent);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tssr_pkg::CFG_BRAKE:   brake_q = i_cfg_data;
                    tssr_pkg::CFG_PLAY:    play_q = i_cfg_data;
                    tssr_pkg::CFG_SHUTTLE: shuttle_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                want_rec = slew_next(i_target_speed, spd_q, rev_q);
                spd_q = want_rec.tape;
                rev_q = want_rec.rev;
                pending_speeds.push_back(want_rec);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[transport_speed_slew_ramp_core] ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    task automatic send_target(input logic signed [SW-1:0] tgt);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_target_speed <= tgt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tssr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // drop valid, then let the last beat drain and the pipeline settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_speeds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] random_step();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return STEP_MAX;
            2: return CW'($urandom_range(1, 1000));
            default: return CW'($urandom_range(1000, 400000));
        endcase
    endfunction

    task automatic load_random_steps();
        write_reg(tssr_pkg::CFG_BRAKE, random_step());
        write_reg(tssr_pkg::CFG_PLAY, random_step());
        write_reg(tssr_pkg::CFG_SHUTTLE, random_step());
    endtask

    function automatic logic signed [SW-1:0] pick_target();
        longint m;
        logic signed [SW-1:0] v;
        case ($urandom_range(0, 9))
            0: m = $urandom_range(0, LIM_STOP - 1);
            1: begin
                case ($urandom_range(0, 3))
                    0: m = LIM_STOP;
                    1: m = LIM_PLAY;
                    2: m = LIM_SHUT;
                    default: m = LIM_NEAR0;
                endcase
                m = m + int'($urandom_range(0, 2)) - 1;
            end
            2, 3: m = $urandom_range(LIM_STOP, LIM_PLAY);
            4, 5, 6: m = $urandom_range(LIM_PLAY + 1, SPD_SPAN);
            7: begin
                v = SW'($urandom);
                return v;
            end
            8: begin
                case ($urandom_range(0, 3))
                    0: return SPD_MIN;
                    1: return SPD_MAX;
                    2: m = SPD_SPAN;
                    default: m = 0;
                endcase
            end
            default: m = $urandom_range(0, 3300);
        endcase
        v = m[SW-1:0];
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    task automatic test_reset_defaults();
        send_target(0);
        send_target(LIM_STOP - 1);
        send_target(LIM_STOP);
        send_target(ONE_Q);
        send_target(LIM_PLAY);
        send_target(LIM_PLAY + 1);
        send_target(-ONE_Q);
        send_target(LIM_SHUT);
        send_target(LIM_SHUT + 1);
        send_target(104858);
        send_target(-104858);
    endtask

    task automatic test_corners();
        wait_idle();
        write_reg(tssr_pkg::CFG_SHUTTLE, STEP_MAX);
        write_reg(CFG_NONE, 24'h5a5a5a);
        repeat (3) send_target(SPD_SPAN);
        send_target(ONE_Q);
        wait_idle();
        write_reg(tssr_pkg::CFG_BRAKE, STEP_MAX);
        write_reg(tssr_pkg::CFG_PLAY, '0);
        // settle on -1 LSB so the next beat hits full-scale negative with the flag clear
        repeat (4) send_target(-1);
        send_target(SPD_MIN);
        send_target(SPD_MAX);
        send_target(0);
        wait_idle();
        write_reg(tssr_pkg::CFG_PLAY, STEP_MAX);
        send_target(ONE_Q);
        send_target(-ONE_Q);
    endtask

    task automatic test_random(input int in_pct, input int out_pct, input int n_items,
                               input bit from_defaults);
        int sent;
        int run;
        logic signed [SW-1:0] tgt;
        wait_idle();
        if (from_defaults) begin
            write_reg(tssr_pkg::CFG_BRAKE, tssr_pkg::BRAKE_RST);
            write_reg(tssr_pkg::CFG_PLAY, tssr_pkg::PLAY_RST);
            write_reg(tssr_pkg::CFG_SHUTTLE, tssr_pkg::SHUTTLE_RST);
        end else begin
            load_random_steps();
        end
        in_idle_pct = in_pct;
        out_idle_pct = out_pct;
        sent = 0;
        while (sent < n_items) begin
            tgt = pick_target();
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            for (int k = 0; k < run && sent < n_items; k++) begin
                send_target(tgt);
                sent++;
            end
            if ($urandom_range(0, 39) == 0) begin
                wait_idle();
                load_random_steps();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        in_idle_pct = 9;
        out_idle_pct = 74;
        test_reset_defaults();
        test_corners();
        test_random(9, 74, 310, 1'b1);
        test_random(74, 9, 310, 1'b0);
        test_random(0, 0, 310, 1'b0);
        wait_idle();
        if (mismatches == 0 && pending_speeds.size() == 0) begin
            $display("[transport_speed_slew_ramp_core] OK");
        end else begin
            $display("[transport_speed_slew_ramp_core] ERROR");
        end
        $finish;
    end

endmodule
